// ===== sv/rmrm_pkg.sv =====
// Shared types and constants for the resampling music ring mixer.
`timescale 1ns / 1ps

package rmrm_pkg;

   localparam int RING_DEPTH_DEFAULT = 16384;

   localparam int SAMPLE_W  = 16;
   localparam int FRAME_W   = 2 * SAMPLE_W;
   localparam int STEP_W    = 20;
   localparam int VOLUME_W  = 16;
   localparam int PHASE_W   = 21;
   localparam int COUNT_W   = 5;
   localparam int OPCODE_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   localparam logic [PHASE_W-1:0]  ONE_Q16    = PHASE_W'(65536);
   localparam logic [STEP_W-1:0]   STEP_MIN   = STEP_W'(4096);
   localparam logic [VOLUME_W-1:0] VOL_UNITY  = VOLUME_W'(32768);
   localparam logic [COUNT_W-1:0]  MAX_WRITES = COUNT_W'(16);

   localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(65536);
   localparam logic [VOLUME_W-1:0] VOLUME_RESET = VOLUME_W'(32768);

   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_MIX   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP   = 2'd0,
      CSR_VOLUME = 2'd1,
      CSR_ENABLE = 2'd2,
      CSR_SPARE  = 2'd3
   } csr_index_type;

   // Control from the sequencer to the shared scale-and-add unit.
   typedef struct packed {
      logic mul_en;   // load the product register this cycle
      logic side;     // 0 works on the left channel, 1 on the right
   } mac_ctrl_type;

endpackage

// ===== sv/resampling_music_ring_mixer_top.sv =====
// Top level: music ring with nearest-neighbor resampling and a saturating mixer.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    opcode, sample_left, sample_right
//   rsp      out        rsp_valid/rsp_ready    mixed_left/right, frames_written,
//                                              free_frames, underrun, overflow
//   csr      in         csr_write_en           csr_index, csr_wdata
//
// Steps: clear and unused opcodes go straight to finish, which loads the result; a
// pass-through mix goes mix, finish; a mix with a pop goes mix, then multiply and add for
// each channel, then finish; a push makes up to 16 ring write attempts, then finishes.
// The push loop makes one attempt per cycle; both channels share one multiplier and adder.
// Reset is synchronous and empties the ring; the ring memory itself is not cleared.
// A new transaction is accepted while the previous result still waits for rsp_ready;
// the sequencer only stalls at its final step if the result register is still full.
`timescale 1ns / 1ps

module resampling_music_ring_mixer_top #(
   parameter int RING_DEPTH = rmrm_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rmrm_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic signed [rmrm_pkg::SAMPLE_W-1:0] req_sample_left,
   input  logic signed [rmrm_pkg::SAMPLE_W-1:0] req_sample_right,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rmrm_pkg::SAMPLE_W-1:0] rsp_mixed_left,
   output logic signed [rmrm_pkg::SAMPLE_W-1:0] rsp_mixed_right,
   output logic [rmrm_pkg::COUNT_W-1:0]         rsp_frames_written,
   output logic [$clog2(RING_DEPTH)-1:0]        rsp_free_frames,
   output logic                                 rsp_underrun,
   output logic                                 rsp_overflow,

   input  logic                                 csr_write_en,
   input  logic [rmrm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rmrm_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(RING_DEPTH);
   localparam logic [AW-1:0] LAST_IDX  = AW'(RING_DEPTH - 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PUSH   = 6'b000010,
      S_MIX    = 6'b000100,
      S_MUL    = 6'b001000,
      S_ADD    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [rmrm_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [rmrm_pkg::VOLUME_W-1:0] volume_ff, volume_in;
   logic                          enable_ff, enable_in;

   // Ring and phase state
   logic [AW-1:0]                  wr_idx_ff, wr_idx_in;
   logic [AW-1:0]                  rd_idx_ff, rd_idx_in;
   logic [rmrm_pkg::PHASE_W-1:0]   phase_ff, phase_in;

   // Per-transaction working registers
   logic [rmrm_pkg::OPCODE_W-1:0]        op_ff, op_in;
   logic signed [rmrm_pkg::SAMPLE_W-1:0] left_ff, left_in;
   logic signed [rmrm_pkg::SAMPLE_W-1:0] right_ff, right_in;
   logic signed [rmrm_pkg::SAMPLE_W-1:0] mix_l_ff, mix_l_in;
   logic signed [rmrm_pkg::SAMPLE_W-1:0] mix_r_ff, mix_r_in;
   logic [rmrm_pkg::COUNT_W-1:0]         written_ff, written_in;
   logic [rmrm_pkg::COUNT_W-1:0]         tries_ff, tries_in;
   logic                                 under_ff, under_in;
   logic                                 over_ff, over_in;
   logic                                 side_ff, side_in;

   // Result register
   logic                                 out_valid_ff, out_valid_in;
   logic signed [rmrm_pkg::SAMPLE_W-1:0] out_l_ff, out_l_in;
   logic signed [rmrm_pkg::SAMPLE_W-1:0] out_r_ff, out_r_in;
   logic [rmrm_pkg::COUNT_W-1:0]         out_written_ff, out_written_in;
   logic [AW-1:0]                        out_free_ff, out_free_in;
   logic                                 out_under_ff, out_under_in;
   logic                                 out_over_ff, out_over_in;

   logic                                 req_fire;
   logic [AW:0]                          used;
   logic [AW-1:0]                        space;
   logic [rmrm_pkg::STEP_W-1:0]          step_eff;
   logic [rmrm_pkg::PHASE_W:0]           phase_sum;
   logic                                 push_more;
   logic                                 result_free;

   logic                                 ram_we;
   logic                                 ram_re;
   logic [rmrm_pkg::FRAME_W-1:0]         ram_rdata;

   rmrm_pkg::mac_ctrl_type               mac_ctrl;
   logic signed [rmrm_pkg::SAMPLE_W-1:0] mac_result;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign result_free = !out_valid_ff || rsp_ready;

   assign used  = (wr_idx_ff >= rd_idx_ff)
                ? ((AW + 1)'(wr_idx_ff) - (AW + 1)'(rd_idx_ff))
                : ((AW + 1)'(wr_idx_ff) + DEPTH_EXT - (AW + 1)'(rd_idx_ff));
   assign space = AW'(DEPTH_EXT - (AW + 1)'(1) - used);

   assign step_eff  = (step_ff < rmrm_pkg::STEP_MIN) ? rmrm_pkg::STEP_MIN : step_ff;
   assign phase_sum = (rmrm_pkg::PHASE_W + 1)'(phase_ff)
                    + (rmrm_pkg::PHASE_W + 1)'(step_eff);
   assign push_more = (phase_ff < rmrm_pkg::ONE_Q16) && (tries_ff < rmrm_pkg::MAX_WRITES);

   assign ram_we = (state_ff == S_PUSH) && push_more && (space != AW'(0));

   assign mac_ctrl.mul_en = (state_ff == S_MUL);
   assign mac_ctrl.side   = side_ff;

   rmrm_ram #(
      .WIDTH (rmrm_pkg::FRAME_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (wr_idx_ff),
      .write_data ({right_ff, left_ff}),
      .read_en    (ram_re),
      .read_addr  (rd_idx_ff),
      .read_data  (ram_rdata)
   );

   rmrm_mac u_mac (
      .clock        (clock),
      .ctrl         (mac_ctrl),
      .music_word   (ram_rdata),
      .volume       (volume_ff),
      .effect_left  (left_ff),
      .effect_right (right_ff),
      .result       (mac_result)
   );

   // Configuration writes
   always_comb begin
      step_in   = step_ff;
      volume_in = volume_ff;
      enable_in = enable_ff;
      if (csr_write_en) begin
         case (rmrm_pkg::csr_index_type'(csr_index))
            rmrm_pkg::CSR_STEP:   step_in   = csr_wdata;
            rmrm_pkg::CSR_VOLUME: volume_in = csr_wdata[rmrm_pkg::VOLUME_W-1:0];
            rmrm_pkg::CSR_ENABLE: enable_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      wr_idx_in   = wr_idx_ff;
      rd_idx_in   = rd_idx_ff;
      phase_in    = phase_ff;
      op_in       = op_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      mix_l_in    = mix_l_ff;
      mix_r_in    = mix_r_ff;
      written_in  = written_ff;
      tries_in    = tries_ff;
      under_in    = under_ff;
      over_in     = over_ff;
      side_in     = side_ff;
      ram_re      = 1'b0;

      out_valid_in   = out_valid_ff && !rsp_ready;
      out_l_in       = out_l_ff;
      out_r_in       = out_r_ff;
      out_written_in = out_written_ff;
      out_free_in    = out_free_ff;
      out_under_in   = out_under_ff;
      out_over_in    = out_over_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_opcode;
               left_in    = req_sample_left;
               right_in   = req_sample_right;
               mix_l_in   = '0;
               mix_r_in   = '0;
               written_in = '0;
               tries_in   = '0;
               under_in   = 1'b0;
               over_in    = 1'b0;
               side_in    = 1'b0;
               case (rmrm_pkg::opcode_type'(req_opcode))
                  rmrm_pkg::OP_PUSH: state_in = S_PUSH;
                  rmrm_pkg::OP_MIX:  state_in = S_MIX;
                  rmrm_pkg::OP_CLEAR: begin
                     wr_idx_in = '0;
                     rd_idx_in = '0;
                     phase_in  = '0;
                     state_in  = S_FINISH;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_PUSH: begin
            if (push_more) begin
               if (space != AW'(0)) begin
                  wr_idx_in  = (wr_idx_ff == LAST_IDX) ? AW'(0) : wr_idx_ff + AW'(1);
                  written_in = written_ff + rmrm_pkg::COUNT_W'(1);
               end else begin
                  over_in = 1'b1;
               end
               phase_in = phase_sum[rmrm_pkg::PHASE_W-1:0];
               tries_in = tries_ff + rmrm_pkg::COUNT_W'(1);
            end else begin
               phase_in = (phase_ff >= rmrm_pkg::ONE_Q16)
                        ? phase_ff - rmrm_pkg::ONE_Q16 : '0;
               state_in = S_FINISH;
            end
         end
         S_MIX: begin
            mix_l_in = left_ff;
            mix_r_in = right_ff;
            if (!enable_ff || (volume_ff == '0)) begin
               state_in = S_FINISH;
            end else if (rd_idx_ff == wr_idx_ff) begin
               under_in = 1'b1;
               state_in = S_FINISH;
            end else begin
               ram_re    = 1'b1;
               rd_idx_in = (rd_idx_ff == LAST_IDX) ? AW'(0) : rd_idx_ff + AW'(1);
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            if (side_ff) begin
               mix_r_in = mac_result;
               state_in = S_FINISH;
            end else begin
               mix_l_in = mac_result;
               side_in  = 1'b1;
               state_in = S_MUL;
            end
         end
         S_FINISH: begin
            if (result_free) begin
               out_valid_in   = 1'b1;
               out_l_in       = mix_l_ff;
               out_r_in       = mix_r_ff;
               out_written_in = written_ff;
               out_free_in    = space;
               out_under_in   = under_ff;
               out_over_in    = over_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= rmrm_pkg::STEP_RESET;
         volume_ff    <= rmrm_pkg::VOLUME_RESET;
         enable_ff    <= 1'b0;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         volume_ff    <= volume_in;
         enable_ff    <= enable_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
      mix_l_ff       <= mix_l_in;
      mix_r_ff       <= mix_r_in;
      written_ff     <= written_in;
      tries_ff       <= tries_in;
      under_ff       <= under_in;
      over_ff        <= over_in;
      side_ff        <= side_in;
      out_l_ff       <= out_l_in;
      out_r_ff       <= out_r_in;
      out_written_ff <= out_written_in;
      out_free_ff    <= out_free_in;
      out_under_ff   <= out_under_in;
      out_over_ff    <= out_over_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_mixed_left     = out_l_ff;
   assign rsp_mixed_right    = out_r_ff;
   assign rsp_frames_written = out_written_ff;
   assign rsp_free_frames    = out_free_ff;
   assign rsp_underrun       = out_under_ff;
   assign rsp_overflow       = out_over_ff;

   // A push never writes more frames than it attempted.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH) |-> (written_ff <= tries_ff))
      else $error("ring writes exceed write attempts");

   // Underrun and overflow come from different opcodes and never appear together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_underrun && rsp_overflow))
      else $error("underrun and overflow reported together");

   // Once a transaction is taken, the block is busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("input accepted again without processing");

   // A push attempts the ring at most the fixed maximum number of times.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frames_written <= rmrm_pkg::MAX_WRITES))
      else $error("frames written above the per-push limit");

   // Popping from the ring only happens when it holds at least one frame.
   assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (rd_idx_ff != wr_idx_ff) && (op_ff == rmrm_pkg::OP_MIX))
      else $error("ring read while empty or outside a mix");

endmodule

// ===== sv/rmrm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module rmrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== sv/rmrm_mac.sv =====
// Shared scale-and-add unit: one multiplier, then truncating rescale and saturation.
`timescale 1ns / 1ps

module rmrm_mac (
   input  logic                                  clock,
   input  rmrm_pkg::mac_ctrl_type                ctrl,
   input  logic [rmrm_pkg::FRAME_W-1:0]          music_word,
   input  logic [rmrm_pkg::VOLUME_W-1:0]         volume,
   input  logic signed [rmrm_pkg::SAMPLE_W-1:0]  effect_left,
   input  logic signed [rmrm_pkg::SAMPLE_W-1:0]  effect_right,
   output logic signed [rmrm_pkg::SAMPLE_W-1:0]  result
);

   logic [rmrm_pkg::VOLUME_W-1:0]        gain;
   logic signed [rmrm_pkg::SAMPLE_W-1:0] music;
   logic signed [rmrm_pkg::SAMPLE_W-1:0] effect;
   logic signed [31:0]                   product;
   logic signed [31:0]                   prod_ff;
   logic signed [31:0]                   biased;
   logic signed [16:0]                   scaled;
   logic signed [17:0]                   sum;

   assign gain   = (volume > rmrm_pkg::VOL_UNITY) ? rmrm_pkg::VOL_UNITY : volume;
   assign music  = ctrl.side ? music_word[31:16] : music_word[15:0];
   assign effect = ctrl.side ? effect_right : effect_left;

   // A 16-bit sample times a gain of at most 2^15 always fits in 32 signed bits.
   assign product = 32'(music) * 32'($signed({1'b0, gain}));

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= product;
      end
   end

   // Adding 2^15-1 before the arithmetic shift makes negative products round toward zero.
   assign biased = prod_ff + (prod_ff[31] ? 32'sd32767 : 32'sd0);
   assign scaled = biased[31:15];
   assign sum    = 18'(effect) + 18'(scaled);

   always_comb begin
      if (sum > 18'(rmrm_pkg::SAT_MAX)) begin
         result = rmrm_pkg::SAT_MAX;
      end else if (sum < 18'(rmrm_pkg::SAT_MIN)) begin
         result = rmrm_pkg::SAT_MIN;
      end else begin
         result = sum[15:0];
      end
   end

endmodule
